### hdl/csdc_pkg.sv
// shared constants, band table and stage record types for the divider calculator
package csdc_pkg;

  localparam int unsigned FreqW  = 32;
  localparam int unsigned XtalW  = 26;
  localparam int unsigned PpbW   = 18;
  localparam int unsigned MW     = 11;
  localparam int unsigned RW     = 3;
  localparam int unsigned IntW   = 8;
  localparam int unsigned NumW   = 20;
  localparam int unsigned P1W    = 18;
  localparam int unsigned P2W    = 20;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 26;

  localparam logic [CfgIdxW-1:0] CfgXtal = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPpb  = 1'b1;

  localparam logic [XtalW-1:0] XtalReset = 26'd25000000;
  localparam logic [FreqW-1:0] FreqMin   = 32'd1500;
  localparam logic [FreqW-1:0] FreqMax   = 32'd280000000;
  localparam logic [NumW-1:0]  FracDen   = 20'hFFFFF;
  localparam logic [31:0]      PpbScale  = 32'd1000000000;

  // quotient bits of vco / xtal (vco < 2^32)
  localparam int unsigned QaW = 32;
  // bits of the fraction quotient, remainder*c/xtal < 2^20
  localparam int unsigned QbW = 20;
  // bits of k = mag*2^31/1e9, mag <= 2^17 gives k < 2^28
  localparam int unsigned KW  = 28;
  localparam int unsigned DivStages = QaW + QbW;

  function automatic logic [3:0] band_of(input logic [FreqW-1:0] f);
    logic [3:0] b;
    b = 4'd15;
    if      (f >= 32'd150000001) b = 4'd0;
    else if (f >= 32'd63000000)  b = 4'd1;
    else if (f >= 32'd27500000)  b = 4'd2;
    else if (f >= 32'd13000000)  b = 4'd3;
    else if (f >= 32'd6500000)   b = 4'd4;
    else if (f >= 32'd3000000)   b = 4'd5;
    else if (f >= 32'd1500000)   b = 4'd6;
    else if (f >= 32'd700000)    b = 4'd7;
    else if (f >= 32'd330000)    b = 4'd8;
    else if (f >= 32'd150000)    b = 4'd9;
    else if (f >= 32'd67000)     b = 4'd10;
    else if (f >= 32'd30300)     b = 4'd11;
    else if (f >= 32'd14000)     b = 4'd12;
    else if (f >= 32'd7000)      b = 4'd13;
    else if (f >= 32'd3500)      b = 4'd14;
    return b;
  endfunction

  function automatic logic [MW-1:0] band_m(input logic [3:0] b);
    logic [MW-1:0] m;
    case (b)
      4'd0:    m = 11'd4;
      4'd1:    m = 11'd6;
      4'd2:    m = 11'd14;
      4'd3:    m = 11'd30;
      4'd4:    m = 11'd62;
      4'd5:    m = 11'd126;
      4'd6:    m = 11'd280;
      4'd7:    m = 11'd600;
      4'd8:    m = 11'd1280;
      4'd9:    m = 11'd1300;
      4'd10:   m = 11'd1500;
      4'd11:   m = 11'd1600;
      default: m = 11'd1800;
    endcase
    return m;
  endfunction

  function automatic logic [RW-1:0] band_r(input logic [3:0] b);
    logic [RW-1:0] r;
    if (b >= 4'd9) r = 3'(b - 4'd8);
    else           r = '0;
    return r;
  endfunction

  // per-item record in the front section
  typedef struct packed {
    logic [FreqW-1:0] freq;
    logic [MW-1:0]    m;
    logic [RW-1:0]    r;
  } front_t;

  // per-item record travelling through the divider
  typedef struct packed {
    logic [FreqW-1:0] vco;
    logic [MW-1:0]    m;
    logic [RW-1:0]    r;
    logic [XtalW-1:0] xtal;
    logic [QaW-1:0]   qa;
    logic [QbW-1:0]   qb;
    logic [52:0]      rem;
    logic [52:0]      num;
  } div_t;

endpackage

### hdl/csdc_front.sv
// correction, clamp, band pick and vco multiply, seven stages
module csdc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [csdc_pkg::FreqW-1:0]      freq_i,
  input  logic [csdc_pkg::KW-1:0]         k_i,
  input  logic                            neg_i,
  output logic                            valid_o,
  output logic [csdc_pkg::FreqW-1:0]      vco_o,
  output logic [csdc_pkg::MW-1:0]         m_o,
  output logic [csdc_pkg::RW-1:0]         r_o
);

  logic [6:0] v_q;
  logic [csdc_pkg::FreqW-1:0] fa_q, fb_q, fc_q;
  logic [csdc_pkg::FreqW-1:0] f0_q;
  logic [59:0] p_q;
  logic n_q;
  logic [csdc_pkg::FreqW-1:0] f1_q;
  csdc_pkg::front_t s2_q;
  logic [csdc_pkg::FreqW-1:0] vco_q;
  logic [csdc_pkg::MW-1:0] m3_q;
  logic [csdc_pkg::RW-1:0] r3_q;

  logic [59:0] p_d;
  logic [csdc_pkg::FreqW-1:0] delta, sum, clamped;
  logic [3:0] band;
  logic [42:0] prod;

  assign p_d = 60'(k_i) * 60'(fc_q);
  // floor of signed product / 2^31
  assign delta = n_q ? 32'((p_q + 60'h7FFFFFFF) >> 31) : 32'(p_q >> 31);
  assign sum = n_q ? f0_q - delta : f0_q + delta;
  assign clamped = (f1_q < csdc_pkg::FreqMin) ? csdc_pkg::FreqMin :
                   (f1_q > csdc_pkg::FreqMax) ? csdc_pkg::FreqMax : f1_q;
  assign band = csdc_pkg::band_of(clamped);
  assign prod = 43'(s2_q.freq) * 43'(s2_q.m);

  // valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  // data stages; the first three carry the frequency while the ppb scale settles
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fa_q <= freq_i;
      fb_q <= fa_q;
      fc_q <= fb_q;
      f0_q <= fc_q;
      p_q  <= p_d;
      n_q  <= neg_i;
      f1_q <= sum;
      s2_q.freq <= clamped;
      s2_q.m    <= csdc_pkg::band_m(band);
      s2_q.r    <= csdc_pkg::band_r(band);
      vco_q <= 32'(prod) << s2_q.r;
      m3_q  <= s2_q.m;
      r3_q  <= s2_q.r;
    end
  end

  assign valid_o = v_q[6];
  assign vco_o   = vco_q;
  assign m_o     = m3_q;
  assign r_o     = r3_q;

endmodule

### hdl/csdc_div.sv
// pipelined restoring divider: vco/xtal integer part then fraction, one bit per stage
module csdc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [csdc_pkg::FreqW-1:0]      vco_i,
  input  logic [csdc_pkg::MW-1:0]         m_i,
  input  logic [csdc_pkg::RW-1:0]         r_i,
  input  logic [csdc_pkg::XtalW-1:0]      xtal_i,
  output logic                            valid_o,
  output csdc_pkg::div_t                  res_o
);

  localparam int unsigned N = csdc_pkg::DivStages;

  logic [N:0] v_q;
  csdc_pkg::div_t st_q [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-1:0], valid_i};
    end
  end

  // stage 0 load; num holds vco for the integer phase
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].vco  <= vco_i;
      st_q[0].m    <= m_i;
      st_q[0].r    <= r_i;
      st_q[0].xtal <= xtal_i;
      st_q[0].qa   <= '0;
      st_q[0].qb   <= '0;
      st_q[0].rem  <= '0;
      st_q[0].num  <= 53'(vco_i);
    end
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_stage
      logic [53:0] trial;
      csdc_pkg::div_t nx;
      if (g < csdc_pkg::QaW) begin : g_int
        // integer quotient bit, vco bits from the top down
        always_comb begin
          nx    = st_q[g];
          trial = {st_q[g].rem, st_q[g].num[csdc_pkg::QaW-1-g]};
          if (st_q[g].xtal != '0 && trial >= 54'(st_q[g].xtal)) begin
            nx.rem = 53'(trial - 54'(st_q[g].xtal));
            nx.qa  = {st_q[g].qa[csdc_pkg::QaW-2:0], 1'b1};
          end else begin
            nx.rem = 53'(trial);
            nx.qa  = {st_q[g].qa[csdc_pkg::QaW-2:0], 1'b0};
          end
        end
      end else begin : g_frac
        logic [52:0] num_in;
        logic [52:0] rem_in;
        // fraction bit; the first stage forms rem*c and starts from its top bits
        always_comb begin
          nx     = st_q[g];
          num_in = st_q[g].num;
          rem_in = st_q[g].rem;
          if (g == csdc_pkg::QaW) begin
            num_in = (53'(st_q[g].rem[csdc_pkg::XtalW-1:0]) << csdc_pkg::NumW) -
                     53'(st_q[g].rem[csdc_pkg::XtalW-1:0]);
            rem_in = num_in >> csdc_pkg::QbW;
          end
          nx.num = num_in;
          trial  = {rem_in, num_in[csdc_pkg::QbW-1-(g-csdc_pkg::QaW)]};
          if (st_q[g].xtal != '0 && trial >= 54'(st_q[g].xtal)) begin
            nx.rem = 53'(trial - 54'(st_q[g].xtal));
            nx.qb  = {st_q[g].qb[csdc_pkg::QbW-2:0], 1'b1};
          end else begin
            nx.rem = 53'(trial);
            nx.qb  = {st_q[g].qb[csdc_pkg::QbW-2:0], 1'b0};
          end
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) st_q[g+1] <= nx;
      end
    end
  endgenerate

  assign valid_o = v_q[N];
  assign res_o   = st_q[N];

endmodule

### hdl/csdc_words.sv
// P1/P2 word forming and output register
module csdc_words (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  csdc_pkg::div_t                  res_i,
  output logic                            valid_o,
  output logic [csdc_pkg::FreqW-1:0]      vco_o,
  output logic [csdc_pkg::MW-1:0]         m_o,
  output logic [csdc_pkg::RW-1:0]         r_o,
  output logic [csdc_pkg::IntW-1:0]       a_o,
  output logic [csdc_pkg::NumW-1:0]       b_o,
  output logic [csdc_pkg::P1W-1:0]        p1_o,
  output logic [csdc_pkg::P2W-1:0]        p2_o
);

  logic v_q;
  logic [csdc_pkg::FreqW-1:0] vco_q;
  logic [csdc_pkg::MW-1:0] m_q;
  logic [csdc_pkg::RW-1:0] r_q;
  logic [csdc_pkg::IntW-1:0] a_q;
  logic [csdc_pkg::NumW-1:0] b_q;
  logic [csdc_pkg::P1W-1:0] p1_q;
  logic [csdc_pkg::P2W-1:0] p2_q;

  logic [26:0] b128;
  logic [6:0]  dd;
  logic [26:0] cdd;

  // 128b/c with b <= c-1: quotient < 128, found by a shift-add identity
  always_comb begin
    b128 = {res_i.qb, 7'd0};
    // floor(x/(2^20-1)) = (x + (x>>20) + 1) >> 20 for x < 2^40 - 1
    dd   = 7'((27'(b128) + 27'(b128 >> 20) + 27'd1) >> 20);
    cdd  = 27'(dd) * 27'(csdc_pkg::FracDen);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vco_q <= res_i.vco;
      m_q   <= res_i.m;
      r_q   <= res_i.r;
      a_q   <= res_i.qa[csdc_pkg::IntW-1:0];
      b_q   <= res_i.qb;
      p1_q  <= 18'({res_i.qa[10:0], 7'd0}) + 18'(dd) - 18'd512;
      p2_q  <= 20'(b128 - cdd);
    end
  end

  assign valid_o = v_q;
  assign vco_o = vco_q;
  assign m_o   = m_q;
  assign r_o   = r_q;
  assign a_o   = a_q;
  assign b_o   = b_q;
  assign p1_o  = p1_q;
  assign p2_o  = p2_q;

endmodule

### hdl/clock_synth_divider_calc_core.sv
// top level of the synthesizer divider calculator
// Usage: one target frequency in per transfer on the target channel, one result
// transfer per item on the result channel, in order. Both channels use valid/ready.
// Throughput: one item per cycle while the receiver takes results.
// Pipeline: from input transfer to result valid, 3 front stages that
// carry the frequency while the ppb scale settles, 4 correction/clamp/band/
// multiply stages, the divider load register plus 52 one-bit-per-stage divider
// stages for the integer and fractional quotients, and one word/output stage.
// The whole pipeline advances together; when the output holds an untaken result
// the pipeline freezes and target_ready_o drops, so no item is lost or repeated.
// Configuration: write cfg_we_i with cfg_idx_i 0 (crystal Hz) or 1 (ppb) while
// idle. A write applies to every transfer accepted at or after the write edge.
// Reset clears all valid bits and loads crystal 25 MHz and ppb 0.
module clock_synth_divider_calc_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [csdc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [csdc_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               target_valid_i,
  output logic                               target_ready_o,
  input  logic [csdc_pkg::FreqW-1:0]         target_freq_i,
  output logic                               result_valid_o,
  input  logic                               result_ready_i,
  output logic [csdc_pkg::FreqW-1:0]         vco_freq_o,
  output logic [csdc_pkg::MW-1:0]            out_divider_o,
  output logic [csdc_pkg::RW-1:0]            r_shift_o,
  output logic [csdc_pkg::IntW-1:0]          pll_integer_o,
  output logic [csdc_pkg::NumW-1:0]          pll_numerator_o,
  output logic [csdc_pkg::P1W-1:0]           pll_word_one_o,
  output logic [csdc_pkg::P2W-1:0]           pll_word_two_o
);

  logic [csdc_pkg::XtalW-1:0] xtal_q;
  logic [csdc_pkg::PpbW-1:0]  ppb_q;
  logic [csdc_pkg::KW-1:0]    k_q;
  logic                       neg_q;
  logic [49:0]                kn_q;
  logic                       en;
  logic                       fv;
  logic [csdc_pkg::FreqW-1:0] fvco;
  logic [csdc_pkg::MW-1:0]    fm;
  logic [csdc_pkg::RW-1:0]    fr;
  logic                       dv;
  csdc_pkg::div_t             dres;
  logic [csdc_pkg::PpbW-1:0]  mag;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xtal_q <= csdc_pkg::XtalReset;
      ppb_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        csdc_pkg::CfgXtal: xtal_q <= cfg_data_i;
        csdc_pkg::CfgPpb:  ppb_q  <= cfg_data_i[csdc_pkg::PpbW-1:0];
        default: ;
      endcase
    end
  end

  // ppb scale k = mag*2^31/1e9 via reciprocal multiply, two registered steps
  assign mag = ppb_q[csdc_pkg::PpbW-1] ? 18'(18'h0 - ppb_q) : ppb_q;
  always_ff @(posedge clk_i) begin
    // mag*2^31/1e9 = floor(mag * 2^31 * R / 2^S); exact for mag <= 2^17 using
    // 2^61/1e9 rounded up, then correct once
    kn_q  <= 50'(50'(mag) * 50'd2305843010);
    k_q   <= 28'(kn_q >> 30) -
             ((28'(kn_q >> 30) * 64'd1000000000 > (64'(mag) << 31)) ? 28'd1 : 28'd0);
    neg_q <= ppb_q[csdc_pkg::PpbW-1];
  end

  assign en = !result_valid_o || result_ready_i;
  assign target_ready_o = en;

  csdc_front u_front (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(target_valid_i), .freq_i(target_freq_i),
    .k_i(k_q), .neg_i(neg_q),
    .valid_o(fv), .vco_o(fvco), .m_o(fm), .r_o(fr)
  );

  csdc_div u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(fv), .vco_i(fvco), .m_i(fm), .r_i(fr), .xtal_i(xtal_q),
    .valid_o(dv), .res_o(dres)
  );

  csdc_words u_words (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(dv), .res_i(dres),
    .valid_o(result_valid_o),
    .vco_o(vco_freq_o), .m_o(out_divider_o), .r_o(r_shift_o),
    .a_o(pll_integer_o), .b_o(pll_numerator_o),
    .p1_o(pll_word_one_o), .p2_o(pll_word_two_o)
  );

endmodule

### hdl/csdc_checker.sv
// port-level checks for the divider calculator, bound to the top level
module csdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        result_valid_o,
  input logic        result_ready_i,
  input logic        target_ready_o,
  input logic [10:0] out_divider_o,
  input logic [2:0]  r_shift_o,
  input logic [31:0] vco_freq_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=> result_valid_o && $stable(vco_freq_o))
    else $error("result dropped while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |-> !target_ready_o)
    else $error("input taken while output stalled");

  a_rshift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && r_shift_o != 3'd0 |-> out_divider_o >= 11'd1300)
    else $error("r shift with small divider");

endmodule

bind clock_synth_divider_calc_core csdc_checker u_chk (.*);
